/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that prop holds at every clock edge outside reset
`define RTFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtfp assertion failed");
// check that cond is never true outside reset
`define RTFP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rtfp forbidden condition seen");
`else
`define RTFP_ASSERT(label, clk, rst_n, prop)
`define RTFP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hdl/rtfp_pkg.sv */
// ----------------------------------------------------------------------------
// rtfp_pkg
// Shared constants, types and decode function of the radar target frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtfp_pkg;

  localparam int unsigned WIN_LEN      = 30;
  localparam int unsigned TARGET_SLOTS = 3;
  localparam int unsigned REC_BASE     = 4;
  localparam int unsigned REC_LEN      = 8;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned SLOT_W       = 2;

  localparam logic [7:0] HDR_B0  = 8'hAA;
  localparam logic [7:0] HDR_B1  = 8'hFF;
  localparam logic [7:0] HDR_B2  = 8'h03;
  localparam logic [7:0] HDR_B3  = 8'h00;
  localparam logic [7:0] TAIL_B0 = 8'h55;
  localparam logic [7:0] TAIL_B1 = 8'hCC;

  localparam logic [15:0] SM_MAG_MASK = 16'h7FFF;
  localparam logic [15:0] SM_POS_BIT  = 16'h8000;

  localparam int unsigned OUT_DATA_W = 72;

  typedef logic [REC_LEN-1:0][7:0] rec_bytes_t;

  // captured frame handed from the window to the output stage
  typedef struct packed {
    logic                               load;
    logic [TARGET_SLOTS-1:0][REC_LEN-1:0][7:0] rec;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] velocity;
    logic [15:0]        resolution;
    logic               present;
  } result_t;

  // bit 15 set means positive; magnitude in bits 14..0
  function automatic logic signed [15:0] sm_decode(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] raw;
    logic [15:0] mag;
    raw = {hi, lo};
    mag = raw & SM_MAG_MASK;
    if ((raw & SM_POS_BIT) != 16'h0000) begin
      return signed'(mag);
    end else begin
      return signed'(16'h0000 - mag);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/rtfp_cell.sv */
// ----------------------------------------------------------------------------
// rtfp_cell
// One byte of the receive window; takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rtfp_cell
  import rtfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

/* hdl/rtfp_emit.sv */
// ----------------------------------------------------------------------------
// rtfp_emit
// Frame result buffer: decodes a matched frame and sends one transfer per slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtfp_emit
  import rtfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire frame_t                frame_i,
  output logic                       busy_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // slot[1:0], pos_x[17:2], pos_y[33:18], velocity[49:34],
  // resolution[65:50], present[66], present_count[68:67], zero pad[71:69]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TARGET_SLOTS - 1);

  logic                    pend_q, pend_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [1:0]              pcount_q, pcount_d;
  result_t                 res_q [TARGET_SLOTS];
  result_t                 res_d [TARGET_SLOTS];
  logic                    out_hs;
  result_t                 cur;

  assign out_hs = pend_q && m_axis_tready_i;

  // decode all slots of the captured frame
  always_comb begin
    pcount_d = pcount_q;
    for (int s = 0; s < TARGET_SLOTS; s++) begin
      res_d[s] = res_q[s];
    end
    if (frame_i.load) begin
      pcount_d = 2'd0;
      for (int s = 0; s < TARGET_SLOTS; s++) begin
        res_d[s].pos_x      = sm_decode(frame_i.rec[s][0], frame_i.rec[s][1]);
        res_d[s].pos_y      = sm_decode(frame_i.rec[s][2], frame_i.rec[s][3]);
        res_d[s].velocity   = sm_decode(frame_i.rec[s][4], frame_i.rec[s][5]);
        res_d[s].resolution = {frame_i.rec[s][7], frame_i.rec[s][6]};
        res_d[s].present    = ({frame_i.rec[s][7], frame_i.rec[s][6]} != 16'h0000);
        pcount_d            = pcount_d + 2'(res_d[s].present);
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    slot_d = slot_q;
    if (frame_i.load) begin
      pend_d = 1'b1;
      slot_d = '0;
    end else if (out_hs) begin
      if (slot_q == LAST_SLOT) begin
        pend_d = 1'b0;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      slot_q <= '0;
    end else begin
      pend_q <= pend_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pcount_q <= pcount_d;
    for (int s = 0; s < TARGET_SLOTS; s++) begin
      res_q[s] <= res_d[s];
    end
  end

  assign cur             = res_q[slot_q];
  assign busy_o          = pend_q;
  assign m_axis_tvalid_o = pend_q;
  assign m_axis_tlast_o  = (slot_q == LAST_SLOT);
  assign m_axis_tdata_o  = {3'b000, pcount_q, cur.present, cur.resolution,
                            cur.velocity, cur.pos_y, cur.pos_x, slot_q};

  `RTFP_ASSERT_NEVER(a_load_while_busy, clk_i, rst_ni, frame_i.load && pend_q)
  `RTFP_ASSERT(a_load_starts_slot0, clk_i, rst_ni,
    frame_i.load |=> (pend_q && slot_q == '0))
  `RTFP_ASSERT(a_drain_after_last, clk_i, rst_ni,
    $fell(pend_q) |-> $past(m_axis_tready_i && slot_q == LAST_SLOT))
  `RTFP_ASSERT(a_slot_in_range, clk_i, rst_ni, pend_q |-> (slot_q <= LAST_SLOT))

endmodule

`default_nettype wire

/* hdl/radar_target_frame_parser.sv */
// ----------------------------------------------------------------------------
// radar_target_frame_parser
// Header/tail frame sync over a 30-byte sliding window of received bytes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle into a row of 29 byte cells that, together with
// the incoming byte, form the 30-byte window. When the newest 30 bytes start
// with AA FF 03 00 and end with 55 CC, the frame is decoded and three target
// results follow on the output, one per transfer, the first in the cycle
// after the tail byte is taken; the window then empties. Input stalls only
// while results of the previous frame still wait and the cells already hold
// 29 bytes, since the three-entry result buffer holds one frame.
`default_nettype none

module radar_target_frame_parser
  import rtfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // rx_byte[7:0]
  input  wire logic [7:0]            s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // slot[1:0], pos_x[17:2], pos_y[33:18], velocity[49:34],
  // resolution[65:50], present[66], present_count[68:67], zero pad[71:69]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  localparam logic [CNT_W-1:0] FULL_M1 = CNT_W'(WIN_LEN - 1);

  logic [7:0]       cell_b [1:WIN_LEN-1];
  logic             in_acc;
  logic             busy;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             match;
  frame_t           frame;

  assign s_axis_tready_o = !(busy && fill_q == FULL_M1);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // newest byte enters at the top cell; each cell takes its upper neighbor
  for (genvar k = 1; k < WIN_LEN; k++) begin : g_cell
    if (k == WIN_LEN - 1) begin : g_top
      rtfp_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(in_acc),
        .byte_i (s_axis_tdata_i),
        .byte_o (cell_b[k])
      );
    end else begin : g_mid
      rtfp_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(in_acc),
        .byte_i (cell_b[k+1]),
        .byte_o (cell_b[k])
      );
    end
  end

  // window after this byte: oldest byte at cell 1, newest on the input
  assign match = (fill_q == FULL_M1)
              && (cell_b[1] == HDR_B0) && (cell_b[2] == HDR_B1)
              && (cell_b[3] == HDR_B2) && (cell_b[4] == HDR_B3)
              && (cell_b[WIN_LEN-1] == TAIL_B0) && (s_axis_tdata_i == TAIL_B1);

  always_comb begin
    frame.load = in_acc && match;
    for (int s = 0; s < TARGET_SLOTS; s++) begin
      for (int j = 0; j < REC_LEN; j++) begin
        frame.rec[s][j] = cell_b[REC_BASE + s * REC_LEN + j + 1];
      end
    end
  end

  // hold at 29 on a mismatch, so the window slides by one byte
  always_comb begin
    fill_d = fill_q;
    if (in_acc) begin
      if (fill_q == FULL_M1) begin
        fill_d = match ? '0 : FULL_M1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  rtfp_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (frame),
    .busy_o         (busy),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
